[rtl/stam_pkg.sv]
`default_nettype none
package stam_pkg;

  localparam int MAX_TERMS   = 32;
  localparam int ADDR_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W       = $clog2(MAX_TERMS + 1);
  localparam int RES_CNT_W   = $clog2(2 * MAX_TERMS + 1);
  localparam int OUT_COUNT_W = 7;
  localparam int VALUE_W     = 32;
  localparam int SUM_W       = 33;
  localparam int POS_W       = 16;
  localparam int ENTRY_W     = 2 * POS_W + VALUE_W;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 72;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // config register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_ROWS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COLS = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_RUN    = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FETCH  = 4'b0010,
    ST_MERGE  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
  } entry_t;

endpackage
`default_nettype wire

[rtl/stam_ram.sv]
`default_nettype none
module stam_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[rtl/sparse_triplet_matrix_add.sv]
// sparse matrix add over two triplet lists (row, column, value)
// input stream: tuser carries the request kind (load A, load B, run),
// tdata carries row, column and a signed 32-bit value of the entry
// a load is taken and appended to its list; a load into a
// full list is dropped and flagged on the results of the next run
// a run merges both lists in row-major order; each merge step reads
// both list memories (fetch state), then uses the shared compare and
// 33-bit adder (merge state); the last result is presented in the same
// cycle that s_axis_tready rises; a run on two empty lists goes straight
// to the finish state; s_axis_tready stays low during a run
// each result is held back one step so the last one can carry tlast and
// the result count; an empty run gives one transfer flagged empty
// the merge waits whenever the output register holds a transfer that the
// receiver has not taken; nothing is lost while m_axis_tready is low
// after a run both lists and the drop flag are cleared
// reset (rst, synchronous) empties both lists and clears the drop flag
// config writes (matrix dimensions) are always taken and do not change
// any result
`default_nettype none
module sparse_triplet_matrix_add (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // in_row, in_col, in_value
  input  wire logic [stam_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type
  input  wire logic [1:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // out_row, out_col, out_value, out_count
  output logic      [stam_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                                   m_axis_tlast,
  // out_empty, overflow_seen
  output logic      [1:0]                        m_axis_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [stam_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [stam_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import stam_pkg::*;

  state_t               state;
  logic [CNT_W-1:0]     a_count;
  logic [CNT_W-1:0]     b_count;
  logic                 dropped;
  logic [CNT_W-1:0]     ia;
  logic [CNT_W-1:0]     ib;
  logic [RES_CNT_W-1:0] res_n;
  logic                 pend_valid;
  logic [POS_W-1:0]     pend_row;
  logic [POS_W-1:0]     pend_col;
  logic [SUM_W-1:0]     pend_value;
  logic [CFG_DATA_W-1:0] num_rows;
  logic [CFG_DATA_W-1:0] num_cols;

  logic [POS_W-1:0]       o_row;
  logic [POS_W-1:0]       o_col;
  logic [SUM_W-1:0]       o_value;
  logic [OUT_COUNT_W-1:0] o_count;
  logic                   o_empty;
  logic                   o_ovf;

  entry_t a_rd;
  entry_t b_rd;
  entry_t in_entry;
  req_type_t req;

  logic s_xfer;
  logic out_busy;
  logic out_load;
  logic wr_a;
  logic wr_b;

  logic               a_ok;
  logic               b_ok;
  logic [2*POS_W-1:0] key_a;
  logic [2*POS_W-1:0] key_b;
  logic               same_pos;
  logic               take_b;
  logic [VALUE_W-1:0] op1;
  logic [VALUE_W-1:0] op2;
  logic [SUM_W-1:0]   sum;
  logic               produce;
  logic [CNT_W-1:0]   ia_next;
  logic [CNT_W-1:0]   ib_next;
  logic [POS_W-1:0]   cand_row;
  logic [POS_W-1:0]   cand_col;

  // dimensions are not checked, so writes are simply taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= '0;
      num_cols <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_ROWS: begin
          num_rows <= cfg_data;
        end
        CFG_NUM_COLS: begin
          num_cols <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_entry      = entry_t'(s_axis_tdata);
  assign req           = req_type_t'(s_axis_tuser);
  assign s_axis_tready = (state == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign out_busy      = m_axis_tvalid && !m_axis_tready;
  assign out_load      = !out_busy && (((state == ST_MERGE) && produce && pend_valid) ||
                                       (state == ST_FINISH));
  assign wr_a = s_xfer && (req == REQ_LOAD_A) && (a_count < CNT_W'(MAX_TERMS));
  assign wr_b = s_xfer && (req == REQ_LOAD_B) && (b_count < CNT_W'(MAX_TERMS));

  stam_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TERMS)) u_list_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (a_count[ADDR_W-1:0]),
    .wr_data (in_entry),
    .rd_addr (ia[ADDR_W-1:0]),
    .rd_data (a_rd)
  );

  stam_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TERMS)) u_list_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (b_count[ADDR_W-1:0]),
    .wr_data (in_entry),
    .rd_addr (ib[ADDR_W-1:0]),
    .rd_data (b_rd)
  );

  // shared compare and add unit
  always_comb begin
    a_ok     = (ia < a_count);
    b_ok     = (ib < b_count);
    key_a    = {a_rd.row, a_rd.col};
    key_b    = {b_rd.row, b_rd.col};
    same_pos = a_ok && b_ok && (key_a == key_b);
    take_b   = !same_pos && !(!b_ok || (a_ok && (key_a < key_b)));
    op1      = take_b ? b_rd.value : a_rd.value;
    op2      = same_pos ? b_rd.value : '0;
    sum      = {op1[VALUE_W-1], op1} + {op2[VALUE_W-1], op2};
    produce  = !same_pos || (sum != '0);
    cand_row = take_b ? b_rd.row : a_rd.row;
    cand_col = take_b ? b_rd.col : a_rd.col;
    ia_next  = (take_b) ? ia : ia + CNT_W'(1);
    ib_next  = (same_pos || take_b) ? ib + CNT_W'(1) : ib;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      a_count       <= '0;
      b_count       <= '0;
      dropped       <= 1'b0;
      ia            <= '0;
      ib            <= '0;
      res_n         <= '0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            case (req)
              REQ_LOAD_A: begin
                if (wr_a) begin
                  a_count <= a_count + CNT_W'(1);
                end else begin
                  dropped <= 1'b1;
                end
              end
              REQ_LOAD_B: begin
                if (wr_b) begin
                  b_count <= b_count + CNT_W'(1);
                end else begin
                  dropped <= 1'b1;
                end
              end
              REQ_RUN: begin
                ia         <= '0;
                ib         <= '0;
                res_n      <= '0;
                pend_valid <= 1'b0;
                if (a_count == '0 && b_count == '0) begin
                  state <= ST_FINISH;
                end else begin
                  state <= ST_FETCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FETCH: begin
          state <= ST_MERGE;
        end
        ST_MERGE: begin
          if (!out_busy) begin
            if (produce) begin
              if (pend_valid) begin
                o_row         <= pend_row;
                o_col         <= pend_col;
                o_value       <= pend_value;
                o_count       <= '0;
                o_empty       <= 1'b0;
                o_ovf         <= dropped;
                m_axis_tlast  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_row   <= cand_row;
              pend_col   <= cand_col;
              pend_value <= sum;
              res_n      <= res_n + RES_CNT_W'(1);
            end
            ia <= ia_next;
            ib <= ib_next;
            if (ia_next < a_count || ib_next < b_count) begin
              state <= ST_FETCH;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (!out_busy) begin
            m_axis_tlast  <= 1'b1;
            o_ovf         <= dropped;
            if (pend_valid) begin
              o_row   <= pend_row;
              o_col   <= pend_col;
              o_value <= pend_value;
              o_count <= OUT_COUNT_W'(res_n);
              o_empty <= 1'b0;
            end else begin
              o_row   <= '0;
              o_col   <= '0;
              o_value <= '0;
              o_count <= '0;
              o_empty <= 1'b1;
            end
            pend_valid <= 1'b0;
            a_count    <= '0;
            b_count    <= '0;
            dropped    <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {o_count, o_value, o_col, o_row};
  assign m_axis_tuser = {o_ovf, o_empty};

  a_cleared_after_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !out_busy) |=> (a_count == '0 && b_count == '0 && !dropped))
    else $error("lists not cleared after a run");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (a_count <= CNT_W'(MAX_TERMS)) && (b_count <= CNT_W'(MAX_TERMS)))
    else $error("list count beyond capacity");

  a_pend_counted: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (res_n != '0))
    else $error("held result not counted");

  a_last_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast && !o_empty) |-> (o_count != '0))
    else $error("last result without a count");

endmodule
`default_nettype wire
